// ===== design/hrhp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrhp_pkg
// Types, codes, keyword tables and match helpers for the request head parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

	localparam int MATCH_LIMIT_DEF = 31;
	localparam int POS_W           = 8;   // position as seen by the match helpers
	localparam int WORD_BITS       = 136; // longest keyword is 17 characters
	localparam int NUM_WORDS       = 10;

	// keyword table indexes
	localparam int WD_GET  = 0;
	localparam int WD_V10  = 3;
	localparam int WD_CLEN = 5;
	localparam int WD_KA   = 8;

	localparam logic [WORD_BITS-1:0] WORD_TEXT [NUM_WORDS] = '{
		WORD_BITS'("GET"),
		WORD_BITS'("POST"),
		WORD_BITS'("HEAD"),
		WORD_BITS'("HTTP/1.0"),
		WORD_BITS'("HTTP/1.1"),
		WORD_BITS'("Content-Length"),
		WORD_BITS'("Transfer-Encoding"),
		WORD_BITS'("Connection"),
		WORD_BITS'("Keep-Alive"),
		WORD_BITS'("keep-alive")
	};

	localparam logic [4:0] WORD_LEN [NUM_WORDS] = '{
		5'd3, 5'd4, 5'd4, 5'd8, 5'd8, 5'd14, 5'd17, 5'd10, 5'd10, 5'd10
	};

	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam logic [2:0] TAG_NONE    = 3'd0;
	localparam logic [2:0] TAG_METHOD  = 3'd1;
	localparam logic [2:0] TAG_PATH    = 3'd2;
	localparam logic [2:0] TAG_VERSION = 3'd3;
	localparam logic [2:0] TAG_KEY     = 3'd4;
	localparam logic [2:0] TAG_VALUE   = 3'd5;

	localparam logic [1:0] ST_BUSY = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

	localparam logic [1:0] METH_GET  = 2'd0;
	localparam logic [1:0] METH_POST = 2'd1;
	localparam logic [1:0] METH_HEAD = 2'd2;

	typedef enum logic [3:0] {
		PH_METHOD,
		PH_SEEK,
		PH_PATH,
		PH_VERSION,
		PH_RL_BAD,
		PH_LINE_START,
		PH_KEY,
		PH_COLON,
		PH_VALUE_START,
		PH_VALUE,
		PH_HDR_LF,
		PH_END_LF,
		PH_ERROR
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       restart;
	} item_t;

	typedef struct packed {
		logic       has_body;
		logic       keep_alive;
		logic       path_is_root;
		logic       version_minor;
		logic [1:0] method_code;
		logic       line_done;
		logic [1:0] status;
		logic [2:0] byte_tag;
	} result_t;

	typedef struct packed {
		phase_t     phase;
		logic [2:0] method_c;
		logic [1:0] version_c;
		logic [2:0] key_c;
		logic [1:0] value_c;
		logic [1:0] path_len;
		logic       saw_cr;
		logic [1:0] held_method;
		logic       held_version;
		logic       held_root;
		logic       held_ka;
		logic       held_body;
	} parse_t;

	localparam parse_t PARSE_CLEAR = '{
		phase: PH_METHOD, method_c: 3'b111, version_c: 2'b11, key_c: 3'b111,
		value_c: 2'b11, path_len: 2'd0, saw_cr: 1'b0, held_method: METH_GET,
		held_version: 1'b1, held_root: 1'b0, held_ka: 1'b0, held_body: 1'b0
	};

	// true when byte b is character pos of keyword id
	function automatic logic word_hit(int unsigned id, logic [POS_W-1:0] pos,
			logic [7:0] b);
		logic [WORD_BITS-1:0] sh;
		logic [POS_W-1:0]     lenx;
		logic [POS_W+2:0]     amt;
		lenx = POS_W'(WORD_LEN[id]);
		// first character sits in the top byte of the word
		amt  = {lenx - pos - POS_W'(1), 3'b000};
		sh   = WORD_TEXT[id] >> amt;
		return (pos < lenx) && (sh[7:0] == b);
	endfunction

	function automatic logic [2:0] narrow3(logic [2:0] c, int unsigned base,
			logic [POS_W-1:0] pos, logic [7:0] b);
		logic [2:0] m;
		for (int i = 0; i < 3; i++)
			m[i] = c[i] & word_hit(base + i, pos, b);
		return m;
	endfunction

	function automatic logic [1:0] narrow2(logic [1:0] c, int unsigned base,
			logic [POS_W-1:0] pos, logic [7:0] b);
		logic [1:0] m;
		for (int i = 0; i < 2; i++)
			m[i] = c[i] & word_hit(base + i, pos, b);
		return m;
	endfunction

	function automatic logic [2:0] full3(logic [2:0] c, int unsigned base,
			logic [POS_W-1:0] pos);
		logic [2:0] m;
		for (int i = 0; i < 3; i++)
			m[i] = c[i] & (pos == POS_W'(WORD_LEN[base + i]));
		return m;
	endfunction

	function automatic logic [1:0] full2(logic [1:0] c, int unsigned base,
			logic [POS_W-1:0] pos);
		logic [1:0] m;
		for (int i = 0; i < 2; i++)
			m[i] = c[i] & (pos == POS_W'(WORD_LEN[base + i]));
		return m;
	endfunction

endpackage

// ===== design/hrhp_in_stage.sv =====
// ----------------------------------------------------------------------------
// hrhp_in_stage
// Input register: holds one request byte until the parse step takes it.
// ----------------------------------------------------------------------------
module hrhp_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [7:0]      s_tdata,   // [7:0] data_byte
	input  logic            s_tuser,   // [0] restart
	input  logic            advance,
	output logic            valid_s1,
	output hrhp_pkg::item_t item_s1
);
	import hrhp_pkg::*;

	logic load;

	assign s_tready = !valid_s1 || advance;
	assign load     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.data_byte <= s_tdata;
			item_s1.restart   <= s_tuser;
		end
	end

endmodule

// ===== design/hrhp_parse.sv =====
// ----------------------------------------------------------------------------
// hrhp_parse
// Parse state machine: tags one byte per step and keeps the request summary.
// ----------------------------------------------------------------------------
module hrhp_parse #(
	parameter int MATCH_LIMIT = hrhp_pkg::MATCH_LIMIT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  hrhp_pkg::item_t   item_s1,
	output hrhp_pkg::result_t result
);
	import hrhp_pkg::*;

	localparam int MP_W = $clog2(MATCH_LIMIT + 1);

	parse_t          ps_q, cur, nx;
	logic [MP_W-1:0] pos_q, cur_pos, nx_pos, pos_inc;
	logic [POS_W-1:0] pos_x;
	logic [7:0]      b;
	logic [2:0]      m3;
	logic [1:0]      m2;

	assign b       = item_s1.data_byte;
	assign cur     = item_s1.restart ? PARSE_CLEAR : ps_q;
	assign cur_pos = item_s1.restart ? '0 : pos_q;
	assign pos_x   = POS_W'(cur_pos);
	assign pos_inc = (cur_pos < MP_W'(MATCH_LIMIT)) ? cur_pos + 1'b1 : cur_pos;
	assign m3      = full3(cur.method_c, WD_GET, pos_x);
	assign m2      = full2(cur.version_c, WD_V10, pos_x);

	// next state
	always_comb begin
		nx     = cur;
		nx_pos = cur_pos;
		case (cur.phase)
			PH_METHOD: begin
				if (b == CH_SP) begin
					nx.method_c = m3;
					if (m3 != '0) begin
						nx.held_method = m3[0] ? METH_GET : (m3[1] ? METH_POST : METH_HEAD);
						nx.phase       = PH_SEEK;
					end else begin
						nx.phase = PH_RL_BAD;
					end
				end else if (b == CH_LF) begin
					nx.phase = PH_ERROR;
				end else begin
					nx.method_c = narrow3(cur.method_c, WD_GET, pos_x, b);
					nx_pos      = pos_inc;
				end
			end
			PH_SEEK: begin
				if (b == CH_SLASH) begin
					nx.path_len = 2'd1;
					nx.phase    = PH_PATH;
				end else if (b == CH_LF) begin
					nx.phase = PH_ERROR;
				end
			end
			PH_PATH: begin
				if (b == CH_SP) begin
					nx.held_root = (cur.path_len == 2'd1);
					nx_pos       = '0;
					nx.version_c = 2'b11;
					nx.saw_cr    = 1'b0;
					nx.phase     = PH_VERSION;
				end else if (b == CH_LF) begin
					nx.phase = PH_ERROR;
				end else if (cur.path_len != 2'd3) begin
					nx.path_len = cur.path_len + 2'd1;
				end
			end
			PH_VERSION: begin
				if (cur.saw_cr) begin
					if (b == CH_LF)
						nx.phase = (cur.version_c != '0) ? PH_LINE_START : PH_ERROR;
				end else if (b == CH_CR) begin
					nx.version_c = m2;
					if (m2 != '0)
						nx.held_version = m2[1];
					nx.saw_cr = 1'b1;
				end else if (b == CH_LF) begin
					nx.phase = PH_ERROR;
				end else begin
					nx.version_c = narrow2(cur.version_c, WD_V10, pos_x, b);
					nx_pos       = pos_inc;
				end
			end
			PH_RL_BAD: begin
				if (b == CH_LF)
					nx.phase = PH_ERROR;
			end
			PH_LINE_START: begin
				if (b == CH_CR) begin
					nx.phase = PH_END_LF;
				end else begin
					nx.key_c = narrow3(3'b111, WD_CLEN, '0, b);
					nx_pos   = MP_W'(1);
					nx.phase = PH_KEY;
				end
			end
			PH_KEY: begin
				if (b == CH_COLON) begin
					nx.key_c = full3(cur.key_c, WD_CLEN, pos_x);
					nx.phase = PH_COLON;
				end else begin
					nx.key_c = narrow3(cur.key_c, WD_CLEN, pos_x, b);
					nx_pos   = pos_inc;
				end
			end
			PH_COLON: begin
				nx.phase = (b == CH_SP) ? PH_VALUE_START : PH_ERROR;
			end
			PH_VALUE_START: begin
				if (b == CH_CR) begin
					nx_pos     = '0;
					nx.value_c = 2'b00;
					nx.phase   = PH_HDR_LF;
				end else begin
					nx.value_c = narrow2(2'b11, WD_KA, '0, b);
					nx_pos     = MP_W'(1);
					nx.phase   = PH_VALUE;
				end
			end
			PH_VALUE: begin
				if (b == CH_CR) begin
					nx.value_c = full2(cur.value_c, WD_KA, pos_x);
					nx.phase   = PH_HDR_LF;
				end else begin
					nx.value_c = narrow2(cur.value_c, WD_KA, pos_x, b);
					nx_pos     = pos_inc;
				end
			end
			PH_HDR_LF: begin
				if (b == CH_LF) begin
					if (cur.key_c[1:0] != '0)
						nx.held_body = 1'b1;
					if (cur.key_c[2])
						nx.held_ka = (cur.value_c != '0);
					nx.phase = PH_LINE_START;
				end else begin
					nx.phase = PH_ERROR;
				end
			end
			PH_END_LF: begin
				if (b == CH_LF) begin
					nx     = PARSE_CLEAR;
					nx_pos = '0;
				end else begin
					nx.phase = PH_ERROR;
				end
			end
			default: begin
				nx.phase = PH_ERROR;
			end
		endcase
	end

	// result of this byte
	always_comb begin
		result = '0;
		case (cur.phase)
			PH_METHOD: begin
				if (b == CH_LF) begin
					result.status    = ST_ERR;
					result.line_done = 1'b1;
				end else if (b != CH_SP) begin
					result.byte_tag = TAG_METHOD;
				end
			end
			PH_SEEK: begin
				if (b == CH_SLASH) begin
					result.byte_tag = TAG_PATH;
				end else if (b == CH_LF) begin
					result.status    = ST_ERR;
					result.line_done = 1'b1;
				end
			end
			PH_PATH: begin
				if (b == CH_LF) begin
					result.status    = ST_ERR;
					result.line_done = 1'b1;
				end else if (b != CH_SP) begin
					result.byte_tag = TAG_PATH;
				end
			end
			PH_VERSION: begin
				if (cur.saw_cr) begin
					if (b == CH_LF) begin
						result.line_done = 1'b1;
						if (cur.version_c == '0)
							result.status = ST_ERR;
					end
				end else if (b == CH_LF) begin
					result.status    = ST_ERR;
					result.line_done = 1'b1;
				end else if (b != CH_CR) begin
					result.byte_tag = TAG_VERSION;
				end
			end
			PH_RL_BAD: begin
				if (b == CH_LF) begin
					result.status    = ST_ERR;
					result.line_done = 1'b1;
				end
			end
			PH_LINE_START, PH_KEY: begin
				if (!(cur.phase == PH_LINE_START && b == CH_CR)
						&& !(cur.phase == PH_KEY && b == CH_COLON))
					result.byte_tag = TAG_KEY;
			end
			PH_COLON: begin
				if (b != CH_SP)
					result.status = ST_ERR;
			end
			PH_VALUE_START, PH_VALUE: begin
				if (b != CH_CR)
					result.byte_tag = TAG_VALUE;
			end
			PH_HDR_LF: begin
				if (b == CH_LF)
					result.line_done = 1'b1;
				else
					result.status = ST_ERR;
			end
			PH_END_LF: begin
				if (b == CH_LF) begin
					result.status        = ST_DONE;
					result.method_code   = cur.held_method;
					result.version_minor = cur.held_version;
					result.path_is_root  = cur.held_root;
					result.keep_alive    = cur.held_ka;
					result.has_body      = cur.held_body;
				end else begin
					result.status = ST_ERR;
				end
			end
			default: begin
				result.status = ST_ERR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q  <= PARSE_CLEAR;
			pos_q <= '0;
		end else if (advance) begin
			ps_q  <= nx;
			pos_q <= nx_pos;
		end
	end

endmodule

// ===== design/hrhp_out_stage.sv =====
// ----------------------------------------------------------------------------
// hrhp_out_stage
// Result register: holds one tagged result until the sink takes it.
// ----------------------------------------------------------------------------
module hrhp_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  hrhp_pkg::result_t result,
	output logic              m_tvalid,
	input  logic              m_tready,
	// [2:0] byte_tag, [4:3] status, [5] line_done, [7:6] method_code,
	// [8] version_minor, [9] path_is_root, [10] keep_alive, [11] has_body
	output logic [15:0]       m_tdata
);
	import hrhp_pkg::*;

	result_t res_q;

	assign m_tdata = {4'b0000, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= result;
	end

endmodule

// ===== design/http_request_head_parser.sv =====
// ----------------------------------------------------------------------------
// http_request_head_parser
// Tags each request byte and reports the request head summary at its end.
//
//   channel  dir  fields
//   s_*      in   tdata: data_byte[7:0]; tuser: restart
//   m_*      out  tdata: byte_tag, status, line_done, method_code,
//                 version_minor, path_is_root, keep_alive, has_body
//
// One item per cycle sustained while the sink keeps up; a byte taken into
// the input register passes through the parse step into the result
// register, where the sink can take it. The parse state updates once for
// each byte stepped through.
// Reset returns the parser to the start of a request line.
// A stalled sink holds the result register and then the input register.
// ----------------------------------------------------------------------------
module http_request_head_parser #(
	parameter int MATCH_LIMIT = hrhp_pkg::MATCH_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tuser,  // [0] restart
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] byte_tag, [4:3] status, [5] line_done, [7:6] method_code,
	// [8] version_minor, [9] path_is_root, [10] keep_alive, [11] has_body
	output logic [15:0] m_tdata
);
	import hrhp_pkg::*;

	logic    valid_s1;
	logic    advance;
	item_t   item_s1;
	result_t result;

	// step when an item waits and the result register is free or draining
	assign advance = valid_s1 && (!m_tvalid || m_tready);

	hrhp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	hrhp_parse #(
		.MATCH_LIMIT (MATCH_LIMIT)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.result  (result)
	);

	hrhp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.result   (result),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the request head parser.
//
// Request byte streams are built up front: a few fixed items, then mostly
// well-formed requests with random paths, headers and values. Some carry
// faults, cut-offs or restarts, and some are bursts of raw noise. A local
// parse model tags every byte as it is taken, and each result item is
// checked field by field against the oldest prediction. Both sides idle at
// random, and once the source holds off until every result is back.
// ----------------------------------------------------------------------------
module tb_top;
	import hrhp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEM_TARGET = 1850;
	localparam int DRAIN_AT    = 700;
	localparam int CALM_LO     = 900;
	localparam int CALM_HI     = 1250;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;  // [7:0] data_byte
	logic        s_tuser = 1'b0; // [0] restart
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [2:0] byte_tag, [4:3] status, [5] line_done, [7:6] method_code,
	// [8] version_minor, [9] path_is_root, [10] keep_alive, [11] has_body
	logic [15:0] m_tdata;

	http_request_head_parser u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// request bytes waiting to be sent, and tags predicted for taken bytes
	item_t   byte_stream [$];
	result_t predicted_tags [$];

	int n_total;
	int n_sent;
	int n_checked;
	int n_heads;
	int n_err;
	int mismatches;
	int cycles;
	bit drained;
	bit restart_next;

	// ------------------------------------------------------------------
	// parse model state
	// ------------------------------------------------------------------
	phase_t     ph;
	int         match_pos;
	logic [2:0] meth_c;
	logic [2:0] ver_c;
	logic [2:0] key_c;
	logic [2:0] val_c;
	int         path_len;
	bit         line_cr;
	logic [1:0] hold_meth;
	logic       hold_ver;
	logic       hold_root;
	logic       hold_ka;
	logic       hold_body;

	function automatic string kw_string(int id);
		case (id)
			WD_GET:       return "GET";
			WD_GET + 1:   return "POST";
			WD_GET + 2:   return "HEAD";
			WD_V10:       return "HTTP/1.0";
			WD_V10 + 1:   return "HTTP/1.1";
			WD_CLEN:      return "Content-Length";
			WD_CLEN + 1:  return "Transfer-Encoding";
			WD_CLEN + 2:  return "Connection";
			WD_KA:        return "Keep-Alive";
			WD_KA + 1:    return "keep-alive";
			default:      return "";
		endcase
	endfunction

	function automatic void clear_parse();
		ph        = PH_METHOD;
		match_pos = 0;
		meth_c    = 3'b111;
		ver_c     = 3'b011;
		key_c     = 3'b111;
		val_c     = 3'b011;
		path_len  = 0;
		line_cr   = 1'b0;
		hold_meth = METH_GET;
		hold_ver  = 1'b1;
		hold_root = 1'b0;
		hold_ka   = 1'b0;
		hold_body = 1'b0;
	endfunction

	// drop candidates that disagree with byte b at the current position
	function automatic logic [2:0] trim_set(logic [2:0] c, int base, int n, logic [7:0] b);
		string      w;
		logic [2:0] r;
		r = c;
		for (int i = 0; i < n; i++) begin
			w = kw_string(base + i);
			if (r[i] && (match_pos >= w.len() || w[match_pos] != b))
				r[i] = 1'b0;
		end
		if (match_pos < MATCH_LIMIT_DEF)
			match_pos++;
		return r;
	endfunction

	// keep candidates whose whole word has been seen
	function automatic logic [2:0] whole_set(logic [2:0] c, int base, int n);
		string      w;
		logic [2:0] r;
		r = '0;
		for (int i = 0; i < n; i++) begin
			w = kw_string(base + i);
			if (c[i] && match_pos == w.len())
				r[i] = 1'b1;
		end
		return r;
	endfunction

	function automatic result_t tag_byte(logic [7:0] b, logic rst);
		result_t    r;
		logic [2:0] m;
		r = '0;
		if (rst)
			clear_parse();
		case (ph)
			PH_METHOD: begin
				if (b == CH_SP) begin
					m = whole_set(meth_c, WD_GET, 3);
					meth_c = m;
					if (m != 0) begin
						hold_meth = m[0] ? METH_GET : (m[1] ? METH_POST : METH_HEAD);
						ph = PH_SEEK;
					end else
						ph = PH_RL_BAD;
				end else if (b == CH_LF) begin
					r.status = ST_ERR;
					r.line_done = 1'b1;
					ph = PH_ERROR;
				end else begin
					r.byte_tag = TAG_METHOD;
					meth_c = trim_set(meth_c, WD_GET, 3, b);
				end
			end
			PH_SEEK: begin
				if (b == CH_SLASH) begin
					r.byte_tag = TAG_PATH;
					path_len = 1;
					ph = PH_PATH;
				end else if (b == CH_LF) begin
					r.status = ST_ERR;
					r.line_done = 1'b1;
					ph = PH_ERROR;
				end
			end
			PH_PATH: begin
				if (b == CH_SP) begin
					hold_root = (path_len == 1);
					match_pos = 0;
					ver_c = 3'b011;
					line_cr = 1'b0;
					ph = PH_VERSION;
				end else if (b == CH_LF) begin
					r.status = ST_ERR;
					r.line_done = 1'b1;
					ph = PH_ERROR;
				end else begin
					r.byte_tag = TAG_PATH;
					if (path_len < 3)
						path_len++;
				end
			end
			PH_VERSION: begin
				if (line_cr) begin
					// skip anything between CR and LF
					if (b == CH_LF) begin
						r.line_done = 1'b1;
						if (ver_c != 0)
							ph = PH_LINE_START;
						else begin
							r.status = ST_ERR;
							ph = PH_ERROR;
						end
					end
				end else if (b == CH_CR) begin
					m = whole_set(ver_c, WD_V10, 2);
					ver_c = m;
					if (m != 0)
						hold_ver = m[1];
					line_cr = 1'b1;
				end else if (b == CH_LF) begin
					r.status = ST_ERR;
					r.line_done = 1'b1;
					ph = PH_ERROR;
				end else begin
					r.byte_tag = TAG_VERSION;
					ver_c = trim_set(ver_c, WD_V10, 2, b);
				end
			end
			PH_RL_BAD: begin
				if (b == CH_LF) begin
					r.status = ST_ERR;
					r.line_done = 1'b1;
					ph = PH_ERROR;
				end
			end
			PH_LINE_START: begin
				if (b == CH_CR)
					ph = PH_END_LF;
				else begin
					match_pos = 0;
					r.byte_tag = TAG_KEY;
					key_c = trim_set(3'b111, WD_CLEN, 3, b);
					ph = PH_KEY;
				end
			end
			PH_KEY: begin
				if (b == CH_COLON) begin
					key_c = whole_set(key_c, WD_CLEN, 3);
					ph = PH_COLON;
				end else begin
					r.byte_tag = TAG_KEY;
					key_c = trim_set(key_c, WD_CLEN, 3, b);
				end
			end
			PH_COLON: begin
				if (b == CH_SP)
					ph = PH_VALUE_START;
				else begin
					r.status = ST_ERR;
					ph = PH_ERROR;
				end
			end
			PH_VALUE_START: begin
				match_pos = 0;
				if (b == CH_CR) begin
					val_c = '0;
					ph = PH_HDR_LF;
				end else begin
					r.byte_tag = TAG_VALUE;
					val_c = trim_set(3'b011, WD_KA, 2, b);
					ph = PH_VALUE;
				end
			end
			PH_VALUE: begin
				if (b == CH_CR) begin
					val_c = whole_set(val_c, WD_KA, 2);
					ph = PH_HDR_LF;
				end else begin
					r.byte_tag = TAG_VALUE;
					val_c = trim_set(val_c, WD_KA, 2, b);
				end
			end
			PH_HDR_LF: begin
				if (b == CH_LF) begin
					r.line_done = 1'b1;
					if (key_c[1:0] != 0)
						hold_body = 1'b1;
					if (key_c[2])
						hold_ka = (val_c != 0);
					ph = PH_LINE_START;
				end else begin
					r.status = ST_ERR;
					ph = PH_ERROR;
				end
			end
			PH_END_LF: begin
				if (b == CH_LF) begin
					r.status = ST_DONE;
					r.method_code = hold_meth;
					r.version_minor = hold_ver;
					r.path_is_root = hold_root;
					r.keep_alive = hold_ka;
					r.has_body = hold_body;
					clear_parse();
				end else begin
					r.status = ST_ERR;
					ph = PH_ERROR;
				end
			end
			default: begin
				r.status = ST_ERR;
				ph = PH_ERROR;
			end
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// stream building
	// ------------------------------------------------------------------
	function automatic void put(logic [7:0] b);
		item_t it;
		it.data_byte = b;
		it.restart = restart_next;
		restart_next = 1'b0;
		byte_stream.push_back(it);
	endfunction

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endfunction

	function automatic void put_eol();
		put(CH_CR);
		put(CH_LF);
	endfunction

	function automatic logic [7:0] pick_byte(logic [7:0] ban_a, logic [7:0] ban_b);
		logic [7:0] b;
		b = ban_a;
		while (b == ban_a || b == ban_b) begin
			if ($urandom_range(3) == 0)
				b = 8'($urandom_range(255));
			else
				b = 8'($urandom_range(8'h7e, 8'h21));
		end
		return b;
	endfunction

	function automatic void put_rand(int n, logic [7:0] ban_a, logic [7:0] ban_b);
		for (int i = 0; i < n; i++)
			put(pick_byte(ban_a, ban_b));
	endfunction

	// a keyword with one character dropped, case-flipped, replaced or added,
	// or the word cut short
	function automatic void put_mangled(string w, logic [7:0] ban_a, logic [7:0] ban_b);
		int         mode;
		int         pos;
		logic [7:0] c;
		mode = $urandom_range(4);
		pos = $urandom_range(w.len() - 1);
		if (mode == 4 && pos == 0)
			pos = 1;
		for (int i = 0; i < w.len(); i++) begin
			c = w[i];
			if (!((mode == 0 && i == pos) || (mode == 4 && i >= pos))) begin
				if (i == pos && mode == 1) begin
					c = c ^ 8'h20;
					if (c == ban_a || c == ban_b)
						c = "x";
				end else if (i == pos && mode == 2)
					c = pick_byte(ban_a, ban_b);
				put(c);
				if (i == pos && mode == 3)
					put(pick_byte(ban_a, ban_b));
			end
		end
	endfunction

	// trailing garbage after a fault, then restart the next request
	function automatic void spoil_tail();
		put_rand($urandom_range(6), 8'h00, 8'h00);
		restart_next = 1'b1;
	endfunction

	function automatic void put_noise();
		int n;
		n = $urandom_range(16, 3);
		for (int i = 0; i < n; i++) begin
			restart_next = ($urandom_range(5) == 0);
			put(8'($urandom_range(255)));
		end
		restart_next = 1'b1;
	endfunction

	function automatic void put_request();
		int fault;
		int nh;
		int sel;
		bit broken;
		broken = 1'b0;
		fault = ($urandom_range(99) < 12) ? $urandom_range(8, 1) : 0;
		if ($urandom_range(4) == 0)
			restart_next = 1'b1;

		sel = $urandom_range(19);
		if (sel == 0) begin
			put_mangled(kw_string(WD_GET + $urandom_range(2)), CH_SP, CH_LF);
			broken = 1'b1;
		end else if (sel == 1) begin
			put_rand($urandom_range(40, 32), CH_SP, CH_LF);
			broken = 1'b1;
		end else
			put_text(kw_string(WD_GET + $urandom_range(2)));
		if (fault == 1) begin
			put(CH_LF);
			spoil_tail();
			return;
		end
		put(CH_SP);

		if ($urandom_range(9) == 0)
			put_rand($urandom_range(3, 1), CH_SLASH, CH_LF);
		if (fault == 2) begin
			put(CH_LF);
			spoil_tail();
			return;
		end
		put(CH_SLASH);
		if ($urandom_range(9) >= 4)
			put_rand($urandom_range(5, 1), CH_SP, CH_LF);
		if (fault == 3) begin
			put(CH_LF);
			spoil_tail();
			return;
		end
		if (fault == 8) begin
			spoil_tail();
			return;
		end
		put(CH_SP);

		if ($urandom_range(99) < 14) begin
			put_mangled(kw_string(WD_V10 + $urandom_range(1)), CH_CR, CH_LF);
			broken = 1'b1;
		end else
			put_text(kw_string(WD_V10 + $urandom_range(1)));
		if (fault == 4) begin
			put(CH_LF);
			spoil_tail();
			return;
		end
		put(CH_CR);
		if ($urandom_range(9) == 0)
			put_rand($urandom_range(2, 1), CH_LF, CH_LF);
		put(CH_LF);

		nh = $urandom_range(4);
		if ((fault == 5 || fault == 6) && nh == 0)
			nh = 1;
		for (int h = 0; h < nh; h++) begin
			sel = $urandom_range(11);
			case (sel)
				0: put_text(kw_string(WD_CLEN));
				1: put_text(kw_string(WD_CLEN + 1));
				5: put_mangled(kw_string(WD_CLEN + $urandom_range(2)), CH_COLON, CH_CR);
				6: put_rand($urandom_range(10, 1), CH_COLON, CH_CR);
				7: begin
					// a colon as the very first key byte is key text
					put(CH_COLON);
					put_rand($urandom_range(4), CH_COLON, CH_COLON);
				end
				8: begin
					put("X");
					put(CH_CR);
					put(CH_LF);
					put_rand($urandom_range(3), CH_COLON, CH_COLON);
				end
				9: put_rand($urandom_range(40, 33), CH_COLON, CH_CR);
				default: put_text(kw_string(WD_CLEN + 2));
			endcase
			put(CH_COLON);
			if (fault == 5 && h == nh - 1) begin
				put(pick_byte(CH_SP, CH_SP));
				spoil_tail();
				return;
			end
			put(CH_SP);

			sel = $urandom_range(7);
			case (sel)
				0, 7: put_text(kw_string(WD_KA));
				1: put_text(kw_string(WD_KA + 1));
				2: ;
				3: put_text("close");
				4: put_mangled(kw_string(WD_KA + $urandom_range(1)), CH_CR, CH_CR);
				5: put_rand($urandom_range(12, 1), CH_CR, CH_CR);
				default: put_rand($urandom_range(36, 32), CH_CR, CH_CR);
			endcase
			put(CH_CR);
			if (fault == 6 && h == nh - 1) begin
				put(pick_byte(CH_LF, CH_LF));
				spoil_tail();
				return;
			end
			put(CH_LF);
		end

		put(CH_CR);
		if (fault == 7) begin
			put(pick_byte(CH_LF, CH_LF));
			spoil_tail();
			return;
		end
		put(CH_LF);
		if (broken)
			restart_next = 1'b1;
	endfunction

	function automatic void fill_stream();
		// extremes of the byte, an early LF fault, then a plain HEAD request
		restart_next = 1'b1;
		put(8'h00);
		put(8'hFF);
		put(CH_LF);
		restart_next = 1'b1;
		put_text("HEAD / HTTP/1.0");
		put_eol();
		put_eol();
		while (byte_stream.size() < ITEM_TARGET) begin
			if ($urandom_range(99) < 8)
				put_noise();
			else
				put_request();
		end
		n_total = byte_stream.size();
	endfunction

	// ------------------------------------------------------------------
	// source
	// ------------------------------------------------------------------
	bit      src_fire;
	bit      src_hold;
	item_t   src_next;
	result_t src_tags;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			src_fire = s_tvalid && s_tready;
			if (src_fire) begin
				src_tags = tag_byte(s_tdata, s_tuser);
				predicted_tags.push_back(src_tags);
				n_sent++;
				if (src_tags.status == ST_DONE)
					n_heads++;
				if (src_tags.status == ST_ERR)
					n_err++;
			end
			if (!s_tvalid || src_fire) begin
				// hold off once until every result is back
				src_hold = (n_sent >= DRAIN_AT && !drained);
				if (src_hold && predicted_tags.size() == 0) begin
					drained = 1'b1;
					src_hold = 1'b0;
				end
				if (!src_hold && byte_stream.size() != 0 &&
						((n_sent >= CALM_LO && n_sent < CALM_HI) ||
						$urandom_range(99) >= 22)) begin
					src_next = byte_stream.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= src_next.data_byte;
					s_tuser <= src_next.restart;
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// sink and checking
	// ------------------------------------------------------------------
	task automatic note_mismatch(string what, int got, int want);
		if (mismatches < 40)
			$display("mismatch at result %0d: %s got %0d, wanted %0d",
				n_checked, what, got, want);
		mismatches++;
	endtask

	task automatic check_result(logic [15:0] d);
		result_t got;
		result_t want;
		got = result_t'(d[11:0]);
		if (predicted_tags.size() == 0) begin
			note_mismatch("result with none pending, tdata", d, 0);
			return;
		end
		want = predicted_tags.pop_front();
		if (d[15:12] != 4'd0)
			note_mismatch("pad bits", d[15:12], 0);
		if (got.byte_tag != want.byte_tag)
			note_mismatch("byte_tag", got.byte_tag, want.byte_tag);
		if (got.status != want.status)
			note_mismatch("status", got.status, want.status);
		if (got.line_done != want.line_done)
			note_mismatch("line_done", got.line_done, want.line_done);
		if (got.method_code != want.method_code)
			note_mismatch("method_code", got.method_code, want.method_code);
		if (got.version_minor != want.version_minor)
			note_mismatch("version_minor", got.version_minor, want.version_minor);
		if (got.path_is_root != want.path_is_root)
			note_mismatch("path_is_root", got.path_is_root, want.path_is_root);
		if (got.keep_alive != want.keep_alive)
			note_mismatch("keep_alive", got.keep_alive, want.keep_alive);
		if (got.has_body != want.has_body)
			note_mismatch("has_body", got.has_body, want.has_body);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else begin
			if (m_tvalid && m_tready) begin
				check_result(m_tdata);
				n_checked++;
			end
			m_tready <= (n_checked >= CALM_LO && n_checked < CALM_HI) ||
				($urandom_range(99) >= 22);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timed out with %0d results outstanding", predicted_tags.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		clear_parse();
		fill_stream();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (n_sent != n_total)
			@(posedge clk);
		while (predicted_tags.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("%0d request bytes tagged and checked, %0d heads completed, %0d error bytes",
			n_checked, n_heads, n_err);
		$display("random stalls on both sides, one calm stretch and one drain pause");
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
design/hrhp_pkg.sv
design/hrhp_in_stage.sv
design/hrhp_parse.sv
design/hrhp_out_stage.sv
design/http_request_head_parser.sv
verif/tb_top.sv
